[src/pcl_pkg.sv]
// ----------------------------------------------------------------------------
// pcl_pkg
// Shared types and constants for the circular list engine.
// ----------------------------------------------------------------------------
package pcl_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [2:0] {
      REQ_INS_HEAD = 3'd0,
      REQ_INS_TAIL = 3'd1,
      REQ_INS_POS  = 3'd2,
      REQ_DEL_HEAD = 3'd3,
      REQ_DEL_TAIL = 3'd4,
      REQ_DEL_POS  = 3'd5,
      REQ_DUMP_FWD = 3'd6,
      REQ_DUMP_REV = 3'd7
   } req_type_type;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_IGNORED  = 2'd1;
   localparam logic [1:0] ST_REJECTED = 2'd2;

   // Memory port request from the control sequencer to the node store.
   typedef struct packed {
      idx_type    raddr;
      logic       nx_we;
      idx_type    nx_waddr;
      idx_type    nx_wdata;
      logic       pv_we;
      idx_type    pv_waddr;
      idx_type    pv_wdata;
      logic       val_we;
      idx_type    val_waddr;
      logic [31:0] val_wdata;
   } mem_req_type;

   typedef struct packed {
      idx_type     nx;
      idx_type     pv;
      logic [31:0] val;
   } mem_rsp_type;

endpackage

[src/pcl_node_store.sv]
// ----------------------------------------------------------------------------
// pcl_node_store
// Node store: value, next and prev arrays, one read address, registered data.
// ----------------------------------------------------------------------------
module pcl_node_store (
   input  logic                 clock,
   input  pcl_pkg::mem_req_type mreq,
   output pcl_pkg::mem_rsp_type mrsp
);

   logic [31:0]       val_mem [pcl_pkg::CAPACITY];
   pcl_pkg::idx_type  nx_mem  [pcl_pkg::CAPACITY];
   pcl_pkg::idx_type  pv_mem  [pcl_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (mreq.val_we) val_mem[mreq.val_waddr] <= mreq.val_wdata;
      if (mreq.nx_we)  nx_mem[mreq.nx_waddr]   <= mreq.nx_wdata;
      if (mreq.pv_we)  pv_mem[mreq.pv_waddr]   <= mreq.pv_wdata;
      mrsp.val <= val_mem[mreq.raddr];
      mrsp.nx  <= nx_mem[mreq.raddr];
      mrsp.pv  <= pv_mem[mreq.raddr];
   end

endmodule

[src/positional_circular_list_engine_core.sv]
// ----------------------------------------------------------------------------
// positional_circular_list_engine_core
// Bounded circular doubly linked list over a one-port-read node store.
// ----------------------------------------------------------------------------
// Flow from transfer: ignored or rejected requests go straight to S_OUT; insert
//   into an empty list passes S_FREE, delete S_WALK and S_RET, insert S_FREE,
//   S_WALK and S_LINK, all ending in S_OUT; positional walks take at most CAPACITY-2 links.
// Dump: the first element follows the node store read, then one per cycle while
//   rsp_ready holds. One request in flight.
// Reset: synchronous; a clearing pass over every node chains the free list
//   and req_ready stays low until it ends.
module positional_circular_list_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic signed [31:0] req_item_value,
   input  logic [6:0]  req_list_position,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic signed [31:0] rsp_element_value,
   output logic [6:0]  rsp_list_length,
   output logic        rsp_last_result
);

   typedef enum logic [7:0] {
      S_INIT = 8'b00000001, // chain the free list after reset
      S_IDLE = 8'b00000010,
      S_FREE = 8'b00000100, // insert: free node's next link back
      S_WALK = 8'b00001000, // follow next links, one per cycle
      S_LINK = 8'b00010000, // insert: second link write
      S_RET  = 8'b00100000, // delete: push node on the free list
      S_DUMP = 8'b01000000,
      S_OUT  = 8'b10000000
   } state_type;

   state_type         state_ff, state_in;
   pcl_pkg::idx_type  head_ff, head_in, tail_ff, tail_in, free_ff, free_in;
   pcl_pkg::cnt_type  count_ff, count_in;
   pcl_pkg::idx_type  cur_ff, cur_in;
   pcl_pkg::cnt_type  steps_ff, steps_in;
   logic              is_ins_ff, is_ins_in, rev_ff, rev_in;
   logic              set_head_ff, set_head_in, set_tail_ff, set_tail_in;
   logic [31:0]       val_ff, val_in;
   logic [1:0]        pst_ff, pst_in;       // status of the request in flight
   pcl_pkg::idx_type  nnode_ff, nnode_in;   // node being inserted
   logic              ovalid_ff, ovalid_in;
   logic [1:0]        ost_ff, ost_in;
   logic [31:0]       oval_ff, oval_in;
   logic              olast_ff, olast_in;
   logic [6:0]        olen_ff, olen_in;

   pcl_pkg::mem_req_type mreq;
   pcl_pkg::mem_rsp_type mrsp;

   pcl_node_store u_store (.clock(clock), .mreq(mreq), .mrsp(mrsp));

   localparam pcl_pkg::cnt_type CAP = pcl_pkg::cnt_type'(pcl_pkg::CAPACITY);

   logic out_free;
   assign out_free = !ovalid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // Clamp the request's position to the usable range; zero means ignore.
   logic [6:0] cnt7, cnt_p1, pos_k;
   always_comb begin
      cnt7 = 7'(count_ff);
      cnt_p1 = cnt7 + 7'd1;
      case (req_type)
         pcl_pkg::REQ_INS_HEAD, pcl_pkg::REQ_DEL_HEAD: pos_k = 7'd1;
         pcl_pkg::REQ_INS_TAIL: pos_k = cnt_p1;
         pcl_pkg::REQ_DEL_TAIL: pos_k = cnt7;
         pcl_pkg::REQ_INS_POS:
            pos_k = (req_list_position > cnt7) ? cnt_p1 : req_list_position;
         pcl_pkg::REQ_DEL_POS:
            pos_k = (req_list_position > cnt7) ? cnt7 : req_list_position;
         default: pos_k = 7'd0;
      endcase
   end

   always_comb begin
      state_in = state_ff; head_in = head_ff; tail_in = tail_ff;
      free_in = free_ff; count_in = count_ff; cur_in = cur_ff;
      steps_in = steps_ff; is_ins_in = is_ins_ff; rev_in = rev_ff;
      set_head_in = set_head_ff; set_tail_in = set_tail_ff;
      val_in = val_ff; pst_in = pst_ff; nnode_in = nnode_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      ost_in = ost_ff; oval_in = oval_ff; olast_in = olast_ff; olen_in = olen_ff;
      mreq = '0;
      mreq.raddr = cur_ff;
      case (state_ff)
         S_INIT: begin
            // chain node i to i+1 for the free list
            mreq.nx_we    = 1'b1;
            mreq.nx_waddr = cur_ff;
            mreq.nx_wdata = cur_ff + pcl_pkg::idx_type'(1);
            cur_in = cur_ff + pcl_pkg::idx_type'(1);
            if (cur_ff == pcl_pkg::idx_type'(pcl_pkg::CAPACITY - 1))
               state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               val_in = req_item_value;
               rev_in = (req_type == pcl_pkg::REQ_DUMP_REV);
               is_ins_in = 1'b0;
               pst_in = pcl_pkg::ST_IGNORED;
               state_in = S_OUT;
               case (req_type)
                  pcl_pkg::REQ_DUMP_FWD, pcl_pkg::REQ_DUMP_REV: begin
                     if (count_ff != '0) begin
                        cur_in = (req_type == pcl_pkg::REQ_DUMP_REV) ? tail_ff : head_ff;
                        mreq.raddr = cur_in;
                        steps_in = count_ff;
                        state_in = S_DUMP;
                     end
                  end
                  pcl_pkg::REQ_INS_HEAD, pcl_pkg::REQ_INS_TAIL,
                  pcl_pkg::REQ_INS_POS: begin
                     if (pos_k != 7'd0) begin
                        if (count_ff >= CAP) begin
                           pst_in = pcl_pkg::ST_REJECTED;
                        end else begin
                           // take the free head; read its next link first
                           is_ins_in = 1'b1;
                           nnode_in = free_ff;
                           mreq.raddr = free_ff;
                           set_head_in = (pos_k == 7'd1);
                           set_tail_in = (pos_k == cnt_p1);
                           // head and tail inserts both go after the tail
                           if (set_head_in || set_tail_in) begin
                              cur_in = tail_ff;
                              steps_in = '0;
                           end else begin
                              cur_in = head_ff;
                              steps_in = pcl_pkg::cnt_type'(pos_k - 7'd2);
                           end
                           state_in = S_FREE;
                        end
                     end
                  end
                  default: begin
                     if (pos_k != 7'd0 && count_ff != '0) begin
                        // the last position is the tail: skip the walk
                        if (pos_k == cnt7) begin
                           cur_in = tail_ff;
                           steps_in = '0;
                        end else begin
                           cur_in = head_ff;
                           steps_in = pcl_pkg::cnt_type'(pos_k - 7'd1);
                        end
                        mreq.raddr = cur_in;
                        state_in = S_WALK;
                     end
                  end
               endcase
            end
         end
         S_FREE: begin
            // advance the free list past the node taken
            free_in = mrsp.nx;
            if (count_ff == '0) begin
               // only element: link it to itself
               mreq.val_we = 1'b1; mreq.val_waddr = nnode_ff; mreq.val_wdata = val_ff;
               mreq.nx_we = 1'b1; mreq.nx_waddr = nnode_ff; mreq.nx_wdata = nnode_ff;
               mreq.pv_we = 1'b1; mreq.pv_waddr = nnode_ff; mreq.pv_wdata = nnode_ff;
               head_in = nnode_ff;
               tail_in = nnode_ff;
               count_in = count_ff + pcl_pkg::cnt_type'(1);
               pst_in = pcl_pkg::ST_DONE;
               state_in = S_OUT;
            end else begin
               mreq.raddr = cur_ff;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // mrsp holds the links of cur
            if (steps_ff != '0) begin
               cur_in = mrsp.nx;
               mreq.raddr = mrsp.nx;
               steps_in = steps_ff - pcl_pkg::cnt_type'(1);
            end else if (is_ins_ff) begin
               // cur is the predecessor, mrsp.nx its successor
               mreq.val_we = 1'b1; mreq.val_waddr = nnode_ff; mreq.val_wdata = val_ff;
               mreq.nx_we = 1'b1; mreq.nx_waddr = nnode_ff; mreq.nx_wdata = mrsp.nx;
               mreq.pv_we = 1'b1; mreq.pv_waddr = mrsp.nx; mreq.pv_wdata = nnode_ff;
               state_in = S_LINK;
            end else begin
               // cur is the node to remove
               count_in = count_ff - pcl_pkg::cnt_type'(1);
               pst_in = pcl_pkg::ST_DONE;
               if (count_ff == pcl_pkg::cnt_type'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end else begin
                  mreq.nx_we = 1'b1; mreq.nx_waddr = mrsp.pv; mreq.nx_wdata = mrsp.nx;
                  mreq.pv_we = 1'b1; mreq.pv_waddr = mrsp.nx; mreq.pv_wdata = mrsp.pv;
                  if (cur_ff == head_ff) head_in = mrsp.nx;
                  if (cur_ff == tail_ff) tail_in = mrsp.pv;
               end
               state_in = S_RET;
            end
         end
         S_LINK: begin
            mreq.nx_we = 1'b1; mreq.nx_waddr = cur_ff; mreq.nx_wdata = nnode_ff;
            mreq.pv_we = 1'b1; mreq.pv_waddr = nnode_ff; mreq.pv_wdata = cur_ff;
            if (set_head_ff) head_in = nnode_ff;
            if (set_tail_ff) tail_in = nnode_ff;
            count_in = count_ff + pcl_pkg::cnt_type'(1);
            pst_in = pcl_pkg::ST_DONE;
            state_in = S_OUT;
         end
         S_RET: begin
            mreq.nx_we = 1'b1; mreq.nx_waddr = cur_ff; mreq.nx_wdata = free_ff;
            free_in = cur_ff;
            state_in = S_OUT;
         end
         S_DUMP: begin
            // hold the read address while the output register is busy
            mreq.raddr = cur_ff;
            if (out_free) begin
               ovalid_in = 1'b1;
               ost_in = pcl_pkg::ST_DONE;
               oval_in = mrsp.val;
               olast_in = (steps_ff == pcl_pkg::cnt_type'(1));
               olen_in = cnt7;
               cur_in = rev_ff ? mrsp.pv : mrsp.nx;
               mreq.raddr = cur_in;
               steps_in = steps_ff - pcl_pkg::cnt_type'(1);
               if (steps_ff == pcl_pkg::cnt_type'(1)) state_in = S_IDLE;
            end
         end
         S_OUT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               ost_in = pst_ff;
               oval_in = '0;
               olast_in = 1'b1;
               olen_in = cnt7;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         head_ff <= '0; tail_ff <= '0; free_ff <= '0; count_ff <= '0;
         cur_ff <= '0; ovalid_ff <= 1'b0; steps_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in; tail_ff <= tail_in;
         free_ff <= free_in; count_ff <= count_in;
         cur_ff <= cur_in; ovalid_ff <= ovalid_in; steps_ff <= steps_in;
      end
      is_ins_ff <= is_ins_in; rev_ff <= rev_in; val_ff <= val_in;
      set_head_ff <= set_head_in; set_tail_ff <= set_tail_in;
      pst_ff <= pst_in; nnode_ff <= nnode_in;
      ost_ff <= ost_in; oval_ff <= oval_in; olast_ff <= olast_in; olen_ff <= olen_in;
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_status = ost_ff;
   assign rsp_element_value = oval_ff;
   assign rsp_list_length = olen_ff;
   assign rsp_last_result = olast_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP) else $error("element count above capacity");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_element_value) && $stable(rsp_list_length) &&
      $stable(rsp_last_result)) else $error("result dropped or changed");
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE) else $error("ready outside idle");

endmodule

[bench/positional_circular_list_engine_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_circular_list_engine_core_test
// Self-checking bench for the circular list engine: directed corner requests
// followed by random request mixes, with random idling on both channels and
// every response compared against a queue-based list predictor.
// ----------------------------------------------------------------------------
module positional_circular_list_engine_core_test;

   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic [1:0]         status;
      logic signed [31:0] element;
      logic [6:0]         length;
      logic               last;
   } rsp_item_type;

   // Scoreboard: a plain value queue stands in for the linked node store.
   class list_scoreboard;
      logic signed [31:0] elements[$];
      rsp_item_type       due[$];

      function void push_rsp(logic [1:0] st, logic signed [31:0] v, logic l);
         rsp_item_type r;
         r.status  = st;
         r.element = v;
         r.length  = 7'(elements.size());
         r.last    = l;
         due.push_back(r);
      endfunction

      function void note_request(pcl_pkg::req_type_type kind, logic signed [31:0] v, int p);
         int cnt;
         int k;
         logic [1:0] st;
         cnt = elements.size();
         st  = pcl_pkg::ST_IGNORED;
         if (kind == pcl_pkg::REQ_DUMP_FWD || kind == pcl_pkg::REQ_DUMP_REV) begin
            if (cnt == 0) begin
               push_rsp(pcl_pkg::ST_IGNORED, 0, 1'b1);
            end else begin
               for (int i = 0; i < cnt; i++) begin
                  k = (kind == pcl_pkg::REQ_DUMP_FWD) ? i : cnt - 1 - i;
                  push_rsp(pcl_pkg::ST_DONE, elements[k], i == cnt - 1);
               end
            end
            return;
         end
         case (kind)
            pcl_pkg::REQ_INS_HEAD, pcl_pkg::REQ_INS_TAIL, pcl_pkg::REQ_INS_POS: begin
               if (kind == pcl_pkg::REQ_INS_HEAD) k = 1;
               else if (kind == pcl_pkg::REQ_INS_TAIL) k = cnt + 1;
               else k = (p > cnt) ? cnt + 1 : p;
               if (k != 0) begin
                  if (cnt >= pcl_pkg::CAPACITY) begin
                     st = pcl_pkg::ST_REJECTED;
                  end else begin
                     elements.insert(k - 1, v);
                     st = pcl_pkg::ST_DONE;
                  end
               end
            end
            default: begin
               if (kind == pcl_pkg::REQ_DEL_HEAD) k = 1;
               else if (kind == pcl_pkg::REQ_DEL_TAIL) k = cnt;
               else k = (p > cnt) ? cnt : p;
               // position zero drops out; any delete on an empty list drops out
               if (!(kind == pcl_pkg::REQ_DEL_POS && p == 0) && cnt != 0) begin
                  elements.delete(k - 1);
                  st = pcl_pkg::ST_DONE;
               end
            end
         endcase
         push_rsp(st, 0, 1'b1);
      endfunction

      // Returns an empty string on a match, else a description of the miss.
      function string check_rsp(rsp_item_type got);
         rsp_item_type e;
         if (due.size() == 0) return "response with nothing pending";
         e = due.pop_front();
         if (got.status !== e.status || got.element !== e.element ||
             got.length !== e.length || got.last !== e.last)
            return $sformatf({"got st=%0d val=%0d len=%0d last=%0d, ",
                              "want st=%0d val=%0d len=%0d last=%0d"},
               got.status, got.element, got.length, got.last,
               e.status, e.element, e.length, e.last);
         return "";
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = '0;
   logic signed [31:0] req_item_value = '0;
   logic [6:0]  req_list_position = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic signed [31:0] rsp_element_value;
   logic [6:0]  rsp_list_length;
   logic        rsp_last_result;

   list_scoreboard sb = new();
   int  mismatches = 0;
   int  cycles = 0;
   bit  steady = 1'b0;   // set to turn idling off on both sides

   positional_circular_list_engine_core dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task report_mismatch(string msg);
      $display("mismatch @%0d: %s", cycles, msg);
      mismatches++;
   endtask

   // Count cycles; bail out well past the slowest legal run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Stall the response side about a third of the time unless steady.
   always @(posedge clock) begin
      rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 33);
   end

   // Note each request transfer and check each response transfer.
   always @(posedge clock) begin
      rsp_item_type got;
      string msg;
      if (!reset && req_valid && req_ready)
         sb.note_request(pcl_pkg::req_type_type'(req_type), req_item_value,
                         req_list_position);
      if (!reset && rsp_valid && rsp_ready) begin
         got.status  = rsp_status;
         got.element = rsp_element_value;
         got.length  = rsp_list_length;
         got.last    = rsp_last_result;
         msg = sb.check_rsp(got);
         if (msg != "") report_mismatch(msg);
      end
   end

   // Drive one request and hold it until the transfer, then maybe idle.
   // Sample ready mid-cycle so the transfer edge is seen without a race.
   task send(pcl_pkg::req_type_type kind, logic signed [31:0] v, int p);
      bit taken;
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_item_value    <= v;
      req_list_position <= 7'(p);
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      if (!steady && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return -1;
         default: return $urandom;
      endcase
   endfunction

   // Random request, biased toward growing (fill) or shrinking the list.
   task random_request(int grow_pct);
      int cnt;
      int p;
      pcl_pkg::req_type_type kind;
      cnt = sb.elements.size();
      p = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(cnt + 2);
      if ($urandom_range(99) < 10)
         kind = $urandom_range(1) ? pcl_pkg::REQ_DUMP_FWD : pcl_pkg::REQ_DUMP_REV;
      else if ($urandom_range(99) < grow_pct)
         kind = pcl_pkg::req_type_type'($urandom_range(2));
      else
         kind = pcl_pkg::req_type_type'($urandom_range(5, 3));
      send(kind, pick_value(), p);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty-list corners: ignored deletes, ignored dumps, position zero.
      send(pcl_pkg::REQ_DUMP_FWD, 0, 0);
      send(pcl_pkg::REQ_DUMP_REV, 0, 0);
      send(pcl_pkg::REQ_DEL_HEAD, 0, 0);
      send(pcl_pkg::REQ_DEL_TAIL, 0, 0);
      send(pcl_pkg::REQ_DEL_POS, 0, 3);
      send(pcl_pkg::REQ_INS_POS, 5, 0);
      // Past-the-end insert on an empty list becomes the only element.
      send(pcl_pkg::REQ_INS_POS, 32'sh7fff_ffff, 127);
      send(pcl_pkg::REQ_DEL_POS, 0, 1);          // delete the only element
      send(pcl_pkg::REQ_INS_HEAD, 32'sh8000_0000, 0);
      send(pcl_pkg::REQ_INS_TAIL, 32'sh7fff_ffff, 0);
      send(pcl_pkg::REQ_INS_POS, 42, 2);
      send(pcl_pkg::REQ_INS_POS, -7, 1);
      send(pcl_pkg::REQ_DUMP_FWD, 0, 0);
      send(pcl_pkg::REQ_DUMP_REV, 0, 0);
      send(pcl_pkg::REQ_DEL_POS, 0, 127);        // past end drops the tail
      send(pcl_pkg::REQ_DEL_POS, 0, 0);
      send(pcl_pkg::REQ_DEL_POS, 0, 2);
      // Fill to capacity, then every insert flavor is rejected (position zero is ignored).
      while (sb.elements.size() < pcl_pkg::CAPACITY)
         send(pcl_pkg::REQ_INS_TAIL, $urandom, 0);
      send(pcl_pkg::REQ_INS_HEAD, 1, 0);
      send(pcl_pkg::REQ_INS_TAIL, 2, 0);
      send(pcl_pkg::REQ_INS_POS, 3, 64);
      send(pcl_pkg::REQ_INS_POS, 4, 0);          // position zero wins over full
      send(pcl_pkg::REQ_DUMP_REV, 0, 0);

      // Random phases: fill, drain, balanced; one phase with no idling.
      for (int i = 0; i < 170; i++) begin
         steady = (i >= 100 && i < 140);
         if (i < 50) random_request(75);
         else if (i < 90) random_request(25);
         else random_request(50);
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (sb.due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && sb.due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[positional_circular_list_engine_core.f]
src/pcl_pkg.sv
src/pcl_node_store.sv
src/positional_circular_list_engine_core.sv
bench/positional_circular_list_engine_core_test.sv
